// ===== hw/rtl/lir_pkg.sv =====
package lir_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned MAX_UPSAMPLE = 64;
  localparam int unsigned ACC_BITS     = 36;
  localparam int unsigned CNT_BITS     = 21;
  localparam int unsigned STEP_BITS    = 24;
  localparam int unsigned IP_BITS      = ACC_BITS - FRAC_BITS;
  localparam int unsigned N_BITS       = $clog2(MAX_UPSAMPLE + 1);
  localparam int unsigned QDEPTH       = 2;
  localparam int unsigned QPTR_BITS    = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS    = $clog2(QDEPTH + 1);
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DAT_BITS = 24;

  localparam logic [CNT_BITS-1:0]  IN_LENGTH_RST  = CNT_BITS'(1000);
  localparam logic [CNT_BITS-1:0]  OUT_LENGTH_RST = CNT_BITS'(1800);
  localparam logic [STEP_BITS-1:0] STEP_RST       = STEP_BITS'(36409);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IN_LENGTH  = 2'd0,
    REG_OUT_LENGTH = 2'd1,
    REG_STEP       = 2'd2
  } lir_reg_e;

  // One queued input item, already classified by the front end.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic [CNT_BITS-1:0]           index;
  } lir_item_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } lir_q_status_t;

  typedef struct packed {
    logic              emit;
    logic              pop;
    logic              last;
    logic [N_BITS-1:0] n;
  } lir_back_status_t;

endpackage

// ===== hw/rtl/lir_front.sv =====
module lir_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [lir_pkg::CNT_BITS-1:0]        in_length_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output lir_pkg::lir_item_t                  item_o
);
  import lir_pkg::*;

  logic [CNT_BITS-1:0] ic_q, ic_d;
  logic                last;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign last       = ({1'b0, ic_q} + (CNT_BITS+1)'(1)) >= {1'b0, in_length_i};

  assign item_o.sample = sample_in_i;
  assign item_o.last   = last;
  assign item_o.index  = ic_q;

  // restart the count on the final item of a block
  assign ic_d = last ? '0 : ic_q + CNT_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= '0;
    end else if (push_o) begin
      ic_q <= ic_d;
    end
  end

endmodule

// ===== hw/rtl/lir_queue.sv =====
module lir_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lir_pkg::lir_item_t   item_i,
  input  logic                 pop_i,
  output lir_pkg::lir_item_t   head_o,
  output lir_pkg::lir_q_status_t status_o
);
  import lir_pkg::*;

  lir_item_t             slots_q [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0]  count_q;

  assign head_o          = slots_q[rd_ptr_q];
  assign status_o.count  = count_q;
  assign status_o.full   = count_q == QCNT_BITS'(QDEPTH);
  assign status_o.empty  = count_q == '0;

  function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
    next_ptr = (p == QPTR_BITS'(QDEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + QCNT_BITS'(1);
      else if (pop_i && !push_i) count_q <= count_q - QCNT_BITS'(1);
    end
  end

endmodule

// ===== hw/rtl/lir_back.sv =====
module lir_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lir_pkg::lir_item_t                     head_i,
  input  logic                                   q_empty_i,
  output logic                                   pop_o,
  input  logic [lir_pkg::CNT_BITS-1:0]           out_length_i,
  input  logic [lir_pkg::STEP_BITS-1:0]          step_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                   block_end_o,
  output lir_pkg::lir_back_status_t              status_o
);
  import lir_pkg::*;

  localparam int unsigned PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;

  logic [ACC_BITS-1:0]           acc_q;
  logic [CNT_BITS-1:0]           oc_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic [N_BITS-1:0]             n_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_end_q;

  logic [IP_BITS-1:0]            ip;
  logic                          behind, room, cap_ok, more, closing, adv, active;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac;
  logic signed [PROD_BITS-1:0]   prod, sum;
  logic signed [SAMPLE_BITS-1:0] interp, value;

  assign ip      = acc_q[ACC_BITS-1:FRAC_BITS];
  assign behind  = {{(CNT_BITS-IP_BITS){1'b0}}, ip} < head_i.index;
  assign room    = ({1'b0, oc_q} + (CNT_BITS+1)'(1)) < {1'b0, out_length_i};
  assign cap_ok  = n_q < N_BITS'(MAX_UPSAMPLE);
  // the final item keeps one slot for the closing output
  assign more    = cap_ok && room &&
                   (head_i.last ? (n_q < N_BITS'(MAX_UPSAMPLE - 1)) : behind);
  assign closing = head_i.last && ({1'b0, oc_q} < {1'b0, out_length_i}) && cap_ok;
  assign adv     = !out_valid_q || !out_stall_i;
  assign active  = !q_empty_i && adv;
  assign pop_o   = active && !more;

  // left + (right - left) * frac, rounded half up
  assign diff   = (SAMPLE_BITS+1)'(head_i.sample) - (SAMPLE_BITS+1)'(prev_q);
  assign frac   = {1'b0, acc_q[FRAC_BITS-1:0]};
  assign prod   = PROD_BITS'(diff) * PROD_BITS'(frac);
  assign sum    = (PROD_BITS'(prev_q) <<< FRAC_BITS) + prod
                  + PROD_BITS'(1 << (FRAC_BITS - 1));
  assign interp = sum[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
  assign value  = behind ? interp : head_i.sample;

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_sample_q;
  assign block_end_o   = out_end_q;

  assign status_o.emit = active && (more || closing);
  assign status_o.pop  = pop_o;
  assign status_o.last = head_i.last;
  assign status_o.n    = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      oc_q        <= '0;
      prev_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (active && (more || closing)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (active) begin
        if (more) begin
          n_q   <= n_q + N_BITS'(1);
          oc_q  <= oc_q + CNT_BITS'(1);
          acc_q <= acc_q + ACC_BITS'(step_i);
        end else begin
          n_q    <= '0;
          prev_q <= head_i.sample;
          if (head_i.last) begin
            acc_q <= '0;
            oc_q  <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (active && more) begin
      out_sample_q <= value;
      out_end_q    <= 1'b0;
    end else if (active && closing) begin
      out_sample_q <= head_i.sample;
      out_end_q    <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/linear_interp_resampler.sv =====
// Channel  Handshake                 Payload
// input    in_valid_i / in_stall_o   sample_in_i
// output   out_valid_o / out_stall_i sample_out_o, block_end_o
// config   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item yields m outputs (at most 64) before its pop; a block's last item is
// popped with its closing output; one datapath emits at most one output per cycle.
// Items enter a two-entry queue, so the input side runs ahead while outputs drain.
// A stalled output holds the back end; the input stalls only when the queue is full.
// Reset clears the position, counters and previous sample and loads the length
// and step registers with their defaults; no clearing pass is needed.
module linear_interp_resampler (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                   block_end_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [lir_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [lir_pkg::CFG_DAT_BITS-1:0]       cfg_data_i
);
  import lir_pkg::*;

  logic [CNT_BITS-1:0]  in_length_q, out_length_q;
  logic [STEP_BITS-1:0] step_q;

  logic             push, pop;
  lir_item_t        item, head;
  lir_q_status_t    q_stat;
  lir_back_status_t bk_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_length_q  <= IN_LENGTH_RST;
      out_length_q <= OUT_LENGTH_RST;
      step_q       <= STEP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (lir_reg_e'(cfg_index_i))
        REG_IN_LENGTH:  in_length_q  <= cfg_data_i[CNT_BITS-1:0];
        REG_OUT_LENGTH: out_length_q <= cfg_data_i[CNT_BITS-1:0];
        REG_STEP:       step_q       <= cfg_data_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  lir_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_in_i (sample_in_i),
    .in_length_i (in_length_q),
    .q_full_i    (q_stat.full),
    .push_o      (push),
    .item_o      (item)
  );

  lir_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (item),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_stat)
  );

  lir_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_empty_i    (q_stat.empty),
    .pop_o        (pop),
    .out_length_i (out_length_q),
    .step_i       (step_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .block_end_o  (block_end_o),
    .status_o     (bk_stat)
  );

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_BITS'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("item pushed into a full queue");

  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.n <= N_BITS'(MAX_UPSAMPLE))
    else $error("per-item output count beyond cap");

  a_n_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |=> bk_stat.n == '0)
    else $error("output count not restarted after pop");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_stat.emit))
    else $error("output valid without an emitted item");

endmodule
